FILE: sv/cch_pkg.sv
// Shared types, constants and CRC32C helpers for the compare coverage hitmap.
// No dependencies; imported by compare_coverage_hitmap_unit and cch_hash.
`timescale 1ns / 1ps

package cch_pkg;

  localparam int unsigned MAP_INDEX_BITS_DEF = 16;
  localparam int unsigned MASK_W             = 16;
  localparam int unsigned PADDR_W            = 3;
  localparam int unsigned PDATA_W            = 32;
  localparam int unsigned NUM_SEEDS          = 16;
  localparam int unsigned SEED_SHIFT         = 27;
  localparam logic [31:0] CRC_POLY           = 32'h82F6_3B78;
  localparam logic [MASK_W-1:0] MASK_RESET   = 16'hFFFF;

  // register index = byte address / 4
  typedef enum logic [0:0] {
    REG_INDEX_MASK = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] program_counter;
    logic [63:0] pc_offset;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [1:0]  func;
  } in_item_t;

  typedef struct packed {
    logic [15:0] map_index;
    logic [4:0]  added_amount;
    logic [7:0]  new_value;
    logic        last_update;
  } out_item_t;

  // hash unit result: unseeded CRC of the location, equal nibble count, top zero run
  typedef struct packed {
    logic [31:0] crc;
    logic [4:0]  count;
    logic [4:0]  zrun;
  } hash_res_t;

  typedef logic [NUM_SEEDS-1:0][31:0] seed_tab_t;

  // one byte of reflected CRC32C, no inversion
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC is linear: crc(seed, d) = crc(0, d) ^ crc(seed, 0). Table holds the seed terms.
  function automatic seed_tab_t build_seed_tab();
    seed_tab_t   tab;
    logic [31:0] c;
    for (int i = 0; i < NUM_SEEDS; i++) begin
      c = 32'(i) << SEED_SHIFT;
      for (int b = 0; b < 8; b++) begin
        c = crc_byte(c, 8'd0);
      end
      tab[i] = c;
    end
    return tab;
  endfunction

  localparam seed_tab_t SEED_TAB = build_seed_tab();

endpackage

FILE: sv/compare_coverage_hitmap_unit.sv
// Compare coverage hitmap: one result beat per cycle at most; a compare causing n hitmap
// writes (1..16) gives its results after the hash completes, one per cycle while the output
// does not stall, and the next compare is taken only after its last write has been issued.
// The byte-serial CRC unit and the one-entry-a-cycle read-modify-write set this.
// After reset the map is swept to zero, one entry a cycle, with input stalled;
// index_mask resets to all ones. Depends on cch_pkg, cch_hash, cch_ram.
`timescale 1ns / 1ps

module compare_coverage_hitmap_unit #(
  parameter int unsigned MAP_INDEX_BITS = cch_pkg::MAP_INDEX_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cch_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cch_pkg::out_item_t             out_item_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cch_pkg::PADDR_W-1:0]    paddr,
  input  logic [cch_pkg::PDATA_W-1:0]    pwdata,
  output logic [cch_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  import cch_pkg::*;

  localparam int unsigned IDX_W = MAP_INDEX_BITS;
  localparam int unsigned DEPTH = 1 << MAP_INDEX_BITS;
  localparam int unsigned MW    = (IDX_W < MASK_W) ? IDX_W : MASK_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_MODIFY
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [3:0]         k_q, k_d;
  logic [IDX_W-1:0]   rd_addr_q, rd_addr_d;
  logic               fwd_hit_q, fwd_hit_d;
  logic [7:0]         fwd_data_q, fwd_data_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic [MASK_W-1:0]  mask_q, mask_d;

  logic               in_accept;
  logic               hash_done;
  hash_res_t          hash_res;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [7:0]         mem_rdata;

  logic [IDX_W-1:0]   mask_ext;
  logic [3:0]         issue_k;
  logic [31:0]        issue_hash;
  logic [IDX_W-1:0]   issue_addr;
  logic [4:0]         diff;
  logic [3:0]         last_k;
  logic [4:0]         amount;
  logic [7:0]         old_val;
  logic [7:0]         new_val;
  logic               out_free;
  logic               cfg_write;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  cch_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_accept),
    .item_i (in_item_i),
    .done_o (hash_done),
    .res_o  (hash_res)
  );

  cch_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(rd_addr_d),
    .rdata_o(mem_rdata)
  );

  // config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign mask_d    = (cfg_write && paddr[2] == REG_INDEX_MASK) ? pwdata[MASK_W-1:0] : mask_q;
  assign prdata    = (paddr[2] == REG_INDEX_MASK) ? PDATA_W'(mask_q) : '0;

  // address of the write about to be read: first write on entering, next one while modifying
  assign mask_ext   = IDX_W'(mask_q[MW-1:0]);
  assign issue_k    = (state_q == ST_READ) ? 4'd0 : (k_q + 4'd1);
  assign issue_hash = hash_res.crc ^ SEED_TAB[issue_k];
  assign issue_addr = issue_hash[IDX_W-1:0] & mask_ext;

  assign diff    = hash_res.count - hash_res.zrun;
  assign last_k  = (diff >= 5'd2) ? 4'(diff - 5'd1) : 4'd0;
  assign amount  = (k_q == 4'd0) ? hash_res.count : diff;
  // the previous write may hit the entry just read
  assign old_val = fwd_hit_q ? fwd_data_q : mem_rdata;
  assign new_val = 8'(old_val + {3'd0, amount});
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    k_d         = k_q;
    rd_addr_d   = rd_addr_q;
    fwd_hit_d   = fwd_hit_q;
    fwd_data_d  = fwd_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = rd_addr_q;
    mem_wdata   = new_val;
    mem_re      = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 8'd0;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        k_d       = 4'd0;
        rd_addr_d = issue_addr;
        mem_re    = 1'b1;
        fwd_hit_d = 1'b0;
        state_d   = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (out_free) begin
          mem_we                  = 1'b1;
          out_valid_d             = 1'b1;
          out_d.map_index         = 16'(rd_addr_q);
          out_d.added_amount      = amount;
          out_d.new_value         = new_val;
          out_d.last_update       = (k_q == last_k);
          if (k_q == last_k) begin
            state_d = ST_IDLE;
          end else begin
            k_d        = k_q + 4'd1;
            rd_addr_d  = issue_addr;
            mem_re     = 1'b1;
            fwd_hit_d  = (issue_addr == rd_addr_q);
            fwd_data_d = new_val;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      k_q         <= 4'd0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      mask_q      <= MASK_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      fwd_hit_q   <= fwd_hit_d;
      out_valid_q <= out_valid_d;
      mask_q      <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    fwd_data_q <= fwd_data_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MODIFY |-> k_q <= last_k)
    else $error("write counter ran past the last write");

  a_fwd_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY && fwd_hit_q) |-> rd_addr_q == $past(rd_addr_q))
    else $error("forwarded value used for a different entry");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY && out_free && k_q == last_k)
      |=> (state_q == ST_IDLE && out_valid_q && out_q.last_update))
    else $error("final write did not close the beat");

  a_amount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.added_amount <= 5'd16)
    else $error("added amount above sixteen");
`endif

endmodule

FILE: sv/cch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cch_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/cch_hash.sv
// Iterative location hash and nibble compare: one location byte and two operand
// nibbles per cycle. Depends on cch_pkg.
`timescale 1ns / 1ps

module cch_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  cch_pkg::in_item_t  item_i,
  output logic               done_o,
  output cch_pkg::hash_res_t res_o
);

  import cch_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [2:0]  step_q, step_d;
  logic [63:0] loc_q, loc_d;
  logic [63:0] a_q, a_d;
  logic [63:0] b_q, b_d;
  logic [1:0]  func_q, func_d;
  logic [31:0] crc_q, crc_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [4:0]  zrun_q, zrun_d;

  always_comb begin
    logic       en;
    logic       eq;
    logic [3:0] na;
    logic [3:0] nb;
    en     = 1'b0;
    eq     = 1'b0;
    na     = 4'd0;
    nb     = 4'd0;
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    loc_d  = loc_q;
    a_d    = a_q;
    b_d    = b_q;
    func_d = func_q;
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    zrun_d = zrun_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = 3'd0;
      loc_d  = item_i.program_counter + item_i.pc_offset;
      a_d    = item_i.operand_a;
      b_d    = item_i.operand_b;
      func_d = item_i.func;
      crc_d  = 32'd0;
      cnt_d  = 5'd0;
      zrun_d = 5'd0;
    end else if (busy_q) begin
      crc_d = crc_byte(crc_q, loc_q[7:0]);
      loc_d = loc_q >> 8;
      a_d   = a_q >> 8;
      b_d   = b_q >> 8;
      // nibbles beyond the operand width leave the counts alone
      en = ({1'b0, step_q} < (4'd1 << func_q));
      for (int j = 0; j < 2; j++) begin
        na = a_q[4*j +: 4];
        nb = b_q[4*j +: 4];
        eq = (na == nb);
        if (en) begin
          if (eq) begin
            cnt_d = cnt_d + 5'd1;
          end
          if (eq && na == 4'd0) begin
            zrun_d = zrun_d + 5'd1;
          end else begin
            zrun_d = 5'd0;
          end
        end
      end
      step_d = step_q + 3'd1;
      if (step_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    loc_q  <= loc_d;
    a_q    <= a_d;
    b_q    <= b_d;
    func_q <= func_d;
    crc_q  <= crc_d;
    cnt_q  <= cnt_d;
    zrun_q <= zrun_d;
  end

  assign done_o      = done_q;
  assign res_o.crc   = crc_q;
  assign res_o.count = cnt_q;
  assign res_o.zrun  = zrun_q;

endmodule
